[rtl/arena_first_fit_allocator_unit_macros.svh]
// assertion macros used by the allocator top level
`ifndef ARENA_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define ARENA_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// condition must hold in the same cycle
`define AFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aff_pkg.sv]
// shared constants, types and helpers of the arena allocator
package aff_pkg;

    localparam int ARENA_BYTES = 16384;
    localparam int HOLE_SLOTS  = 48;
    localparam int HDR_BYTES   = 4;
    localparam int SPLIT_SLACK = 16;

    localparam int IDX_W   = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(HOLE_SLOTS + 1);
    localparam int FIELD_W = 15;
    localparam int HADDR_W = 14;
    localparam int OFF_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int NEED_W  = 17;
    localparam int OP_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

    // one free-list entry
    typedef struct packed {
        logic [OFF_W-1:0]   off;
        logic [FIELD_W-1:0] size;
    } hole_t;

    // round a byte count up to a multiple of four
    function automatic logic [SIZE_W-1:0] round4(input logic [FIELD_W-1:0] s);
        logic [SIZE_W-1:0] t;
        t = {1'b0, s} + SIZE_W'(3);
        return {t[SIZE_W-1:2], 2'b00};
    endfunction

endpackage

[rtl/aff_in_if.sv]
// request channel of the arena allocator
interface aff_in_if;
    import aff_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] request_size;
    logic               block_present;
    logic [FIELD_W-1:0] block_address;
    logic [FIELD_W-1:0] block_size;

    modport source (output valid, op, request_size, block_present, block_address,
                    block_size, input ready);
    modport sink (input valid, op, request_size, block_present, block_address,
                  block_size, output ready);
endinterface

[rtl/aff_out_if.sv]
// result channel of the arena allocator
interface aff_out_if;
    import aff_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [FIELD_W-1:0] data_address;
    logic               header_write;
    logic [HADDR_W-1:0] header_address;
    logic [FIELD_W-1:0] header_value;
    logic               copy_request;
    logic [FIELD_W-1:0] copy_from;
    logic [FIELD_W-1:0] copy_to;
    logic [FIELD_W-1:0] copy_length;
    logic [FIELD_W-1:0] used_bytes;
    logic               out_of_room;

    modport source (output valid, ok, data_address, header_write, header_address,
                    header_value, copy_request, copy_from, copy_to, copy_length,
                    used_bytes, out_of_room, input ready);
    modport sink (input valid, ok, data_address, header_write, header_address,
                  header_value, copy_request, copy_from, copy_to, copy_length,
                  used_bytes, out_of_room, output ready);
endinterface

[rtl/arena_first_fit_allocator_unit.sv]
// top level of the arena allocator with first-fit free list
//
// Requests arrive on in_chan (valid/ready): allocate, free or resize.
// Each request gives exactly one result transfer on out_chan.
// The free list is a ring of hole cells that rotates one cell per cycle past
// a single fit checker at the head, so a search always takes one full turn.
// Steps: a free, in-place resize, zero size or undefined op goes from decide
//   to done; an allocate or moving resize first runs a full ring turn and a
//   post step, and a move adds a free step before done.
// One request is worked on at a time.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stalled receiver holds the block only when a
// second result is ready before the first has been taken.
// cfg_write with cfg_data sets arena_capacity (saturated) and empties the
// allocator: high-water mark, newest block and free-list count.
// Reset (rst_n low, asynchronous) does the same with capacity zero.
// Free-list cells hold no reset; only entries below the count are read.
module arena_first_fit_allocator_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [aff_pkg::FIELD_W-1:0] cfg_data,
    aff_in_if.sink                 in_chan,
    aff_out_if.source              out_chan
);
    import aff_pkg::*;
    `include "arena_first_fit_allocator_unit_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_POST,
        S_FREE,
        S_DONE
    } state_t;

    state_t state_reg;

    // allocator state
    logic [FIELD_W-1:0] cap_reg;
    logic [FIELD_W-1:0] hw_reg;
    logic [FIELD_W-1:0] newest_reg;
    logic               newest_valid_reg;
    logic [CNT_W-1:0]   count_reg;

    // latched request
    logic [OP_W-1:0]    op_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               present_reg;
    logic [FIELD_W-1:0] baddr_reg;
    logic [FIELD_W-1:0] bsize_reg;
    logic               move_reg;

    // search bookkeeping
    logic [IDX_W-1:0]   k_reg;
    logic               found_reg;
    logic               split_reg;
    logic [IDX_W-1:0]   m_reg;
    logic [OFF_W-1:0]   at_reg;
    hole_t              last_reg;

    // result being built
    logic               res_ok_reg;
    logic [FIELD_W-1:0] res_addr_reg;
    logic               res_hw_reg;
    logic [HADDR_W-1:0] res_haddr_reg;
    logic [FIELD_W-1:0] res_hval_reg;
    logic               res_cp_reg;
    logic [FIELD_W-1:0] res_cfrom_reg;
    logic [FIELD_W-1:0] res_clen_reg;
    logic               res_oor_reg;

    // output register
    logic               out_valid_reg;
    logic               o_ok_reg;
    logic [FIELD_W-1:0] o_addr_reg;
    logic               o_hw_reg;
    logic [HADDR_W-1:0] o_haddr_reg;
    logic [FIELD_W-1:0] o_hval_reg;
    logic               o_cp_reg;
    logic [FIELD_W-1:0] o_cfrom_reg;
    logic [FIELD_W-1:0] o_cto_reg;
    logic [FIELD_W-1:0] o_clen_reg;
    logic [FIELD_W-1:0] o_used_reg;
    logic               o_oor_reg;
    logic               out_load;

    // ring wiring
    hole_t              cells_q [HOLE_SLOTS];
    hole_t              tail_in;
    hole_t              head;
    logic               load_go;
    logic [IDX_W-1:0]   load_idx;
    hole_t              load_data;

    logic [NEED_W-1:0]  need;
    logic               fit;
    logic               split_ok;
    logic               take;
    logic [FIELD_W-1:0] room;
    logic               bump_fail;
    logic [FIELD_W-1:0] blk_off;
    logic               blk_valid;
    logic               blk_newest;
    logic               fr_append;
    logic [SIZE_W-1:0]  bsz4;
    hole_t              fr_entry;
    logic               ip_ok;
    logic [FIELD_W-1:0] cap_sat;

    // request footprint with header
    assign need      = NEED_W'(size_reg) + NEED_W'(HDR_BYTES);
    assign head      = cells_q[0];
    assign fit       = NEED_W'(head.size) >= need;
    assign split_ok  = NEED_W'(head.size) >= need + NEED_W'(HDR_BYTES + SPLIT_SLACK);
    assign take      = (state_reg == S_SCAN) && !found_reg &&
                       (CNT_W'(k_reg) < count_reg) && fit;

    // head entry goes to the tail, trimmed when it is split
    always_comb
    begin
        tail_in = head;
        if (take && split_ok)
        begin
            tail_in.off  = head.off + OFF_W'(HDR_BYTES) + size_reg;
            tail_in.size = head.size - FIELD_W'(need);
        end
    end

    // bump room above the high-water mark
    assign room      = (cap_reg > hw_reg) ? cap_reg - hw_reg : '0;
    assign bump_fail = need > NEED_W'(room);

    // block header offset and free decision
    assign blk_off    = baddr_reg - FIELD_W'(HDR_BYTES);
    assign blk_valid  = (baddr_reg >= FIELD_W'(HDR_BYTES)) &&
                        (blk_off < FIELD_W'(ARENA_BYTES));
    assign blk_newest = blk_valid && newest_valid_reg && (blk_off == newest_reg);
    assign fr_append  = blk_valid && !blk_newest && (count_reg < CNT_W'(HOLE_SLOTS));
    assign bsz4       = SIZE_W'(bsize_reg) + SIZE_W'(HDR_BYTES);
    assign fr_entry.off  = OFF_W'(blk_off);
    assign fr_entry.size = bsz4[SIZE_W-1] ? {FIELD_W{1'b1}} : bsz4[FIELD_W-1:0];

    // in-place resize of the newest block
    assign ip_ok = blk_newest && (cap_reg >= blk_off) &&
                   (need <= NEED_W'(cap_reg - blk_off));

    assign cap_sat = (cfg_data > FIELD_W'(ARENA_BYTES)) ? FIELD_W'(ARENA_BYTES) : cfg_data;

    // output register takes a new result
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_chan.ready);

    // direct cell writes: swap-remove fix or free-list append
    always_comb
    begin
        load_go   = 1'b0;
        load_idx  = count_reg[IDX_W-1:0];
        load_data = fr_entry;
        if ((state_reg == S_POST) && found_reg && !split_reg)
        begin
            load_go   = 1'b1;
            load_idx  = m_reg;
            load_data = last_reg;
        end
        else if (((state_reg == S_DECIDE) && (op_reg == OP_FREE)) ||
                 (state_reg == S_FREE))
        begin
            load_go = fr_append;
        end
    end

    // hole ring
    genvar gi;
    generate
        for (gi = 0; gi < HOLE_SLOTS; gi++)
        begin : g_cell
            hole_t nb;
            if (gi == HOLE_SLOTS - 1)
            begin : g_tail
                assign nb = tail_in;
            end
            else
            begin : g_mid
                assign nb = cells_q[gi + 1];
            end
            aff_cell u_cell (
                .clk       (clk),
                .shift_en  (state_reg == S_SCAN),
                .shift_in  (nb),
                .load_en   (load_go && (load_idx == IDX_W'(gi))),
                .load_data (load_data),
                .q         (cells_q[gi])
            );
        end
    endgenerate

    // sequencer, allocator state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cap_reg          <= '0;
            hw_reg           <= '0;
            newest_reg       <= '0;
            newest_valid_reg <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            split_reg        <= 1'b0;
            k_reg            <= '0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                cap_reg          <= cap_sat;
                hw_reg           <= '0;
                newest_reg       <= '0;
                newest_valid_reg <= 1'b0;
                count_reg        <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_chan.valid)
                    begin
                        op_reg        <= in_chan.op;
                        size_reg      <= round4(in_chan.request_size);
                        present_reg   <= in_chan.block_present;
                        baddr_reg     <= in_chan.block_address;
                        bsize_reg     <= in_chan.block_size;
                        res_ok_reg    <= 1'b0;
                        res_addr_reg  <= '0;
                        res_hw_reg    <= 1'b0;
                        res_haddr_reg <= '0;
                        res_hval_reg  <= '0;
                        res_cp_reg    <= 1'b0;
                        res_cfrom_reg <= '0;
                        res_clen_reg  <= '0;
                        res_oor_reg   <= 1'b0;
                        state_reg     <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    move_reg  <= 1'b0;
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    split_reg <= 1'b0;
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_FREE:
                        begin
                            res_ok_reg <= 1'b1;
                            if (blk_newest)
                            begin
                                hw_reg <= blk_off;
                            end
                            else if (fr_append)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        OP_ALLOC, OP_RESIZE:
                        begin
                            if ((op_reg == OP_RESIZE) && present_reg && ip_ok)
                            begin
                                res_ok_reg    <= 1'b1;
                                res_hw_reg    <= 1'b1;
                                res_haddr_reg <= blk_off[HADDR_W-1:0];
                                res_hval_reg  <= size_reg[FIELD_W-1:0];
                                res_addr_reg  <= baddr_reg;
                                hw_reg        <= FIELD_W'(NEED_W'(blk_off) + need);
                            end
                            else if (size_reg != '0)
                            begin
                                move_reg  <= (op_reg == OP_RESIZE) && present_reg;
                                state_reg <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_ok_reg <= 1'b0;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // first fit, and the last live entry for a swap-remove
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        split_reg <= split_ok;
                        m_reg     <= k_reg;
                        at_reg    <= head.off;
                    end
                    if (CNT_W'(k_reg) + CNT_W'(1) == count_reg)
                    begin
                        last_reg <= head;
                    end
                    k_reg <= k_reg + IDX_W'(1);
                    if (k_reg == IDX_W'(HOLE_SLOTS - 1))
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    state_reg <= S_DONE;
                    if (found_reg)
                    begin
                        if (!split_reg)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                        res_ok_reg    <= 1'b1;
                        res_hw_reg    <= 1'b1;
                        res_haddr_reg <= at_reg[HADDR_W-1:0];
                        res_hval_reg  <= size_reg[FIELD_W-1:0];
                        res_addr_reg  <= FIELD_W'(at_reg + OFF_W'(HDR_BYTES));
                        if (move_reg)
                        begin
                            state_reg <= S_FREE;
                        end
                    end
                    else if (bump_fail)
                    begin
                        res_oor_reg <= 1'b1;
                    end
                    else
                    begin
                        res_ok_reg       <= 1'b1;
                        res_hw_reg       <= 1'b1;
                        res_haddr_reg    <= hw_reg[HADDR_W-1:0];
                        res_hval_reg     <= size_reg[FIELD_W-1:0];
                        res_addr_reg     <= hw_reg + FIELD_W'(HDR_BYTES);
                        newest_reg       <= hw_reg;
                        newest_valid_reg <= 1'b1;
                        hw_reg           <= FIELD_W'(NEED_W'(hw_reg) + need);
                        if (move_reg)
                        begin
                            state_reg <= S_FREE;
                        end
                    end
                end
                S_FREE:
                begin
                    // old block released after the move
                    res_cp_reg    <= 1'b1;
                    res_cfrom_reg <= baddr_reg;
                    res_clen_reg  <= (SIZE_W'(bsize_reg) < size_reg) ?
                                     bsize_reg : size_reg[FIELD_W-1:0];
                    if (blk_newest)
                    begin
                        hw_reg <= blk_off;
                    end
                    else if (fr_append)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        o_ok_reg      <= res_ok_reg;
                        o_addr_reg    <= res_addr_reg;
                        o_hw_reg      <= res_hw_reg;
                        o_haddr_reg   <= res_haddr_reg;
                        o_hval_reg    <= res_hval_reg;
                        o_cp_reg      <= res_cp_reg;
                        o_cfrom_reg   <= res_cfrom_reg;
                        o_cto_reg     <= res_cp_reg ? res_addr_reg : '0;
                        o_clen_reg    <= res_clen_reg;
                        o_used_reg    <= hw_reg;
                        o_oor_reg     <= res_oor_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // channel drive
    assign in_chan.ready           = (state_reg == S_IDLE);
    assign out_chan.valid          = out_valid_reg;
    assign out_chan.ok             = o_ok_reg;
    assign out_chan.data_address   = o_addr_reg;
    assign out_chan.header_write   = o_hw_reg;
    assign out_chan.header_address = o_haddr_reg;
    assign out_chan.header_value   = o_hval_reg;
    assign out_chan.copy_request   = o_cp_reg;
    assign out_chan.copy_from      = o_cfrom_reg;
    assign out_chan.copy_to        = o_cto_reg;
    assign out_chan.copy_length    = o_clen_reg;
    assign out_chan.used_bytes     = o_used_reg;
    assign out_chan.out_of_room    = o_oor_reg;

    // checks
    `AFF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(HOLE_SLOTS),
        "free-list count past its slots")
    `AFF_ASSERT_NOW(a_hw_in_cap, 1'b1, hw_reg <= cap_reg,
        "high-water mark above capacity")
    `AFF_ASSERT_NEXT(a_scan_turn, (state_reg == S_SCAN) && (k_reg == IDX_W'(HOLE_SLOTS - 1)),
        state_reg == S_POST, "ring turn did not end in post step")
    `AFF_ASSERT_NEXT(a_fit_no_oor, (state_reg == S_POST) && found_reg,
        !res_oor_reg, "out of room flagged after a free-list fit")
endmodule

[rtl/aff_cell.sv]
// one free-list cell of the rotating hole chain
module aff_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  aff_pkg::hole_t shift_in,
    input  logic          load_en,
    input  aff_pkg::hole_t load_data,
    output aff_pkg::hole_t q
);
    import aff_pkg::*;

    hole_t entry_reg;

    // direct load wins over the rotation step
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            entry_reg <= load_data;
        end
        else if (shift_en)
        begin
            entry_reg <= shift_in;
        end
    end

    assign q = entry_reg;
endmodule
